@@ rtl/core/lrbg_pkg.sv @@
package lrbg_pkg;

  // Number of weight, feature and gradient cells in the chain.
  localparam int MAX_PARAMS = 16;
  localparam int IDX_W      = $clog2(MAX_PARAMS);
  localparam int CNT_W      = $clog2(MAX_PARAMS + 1);

  // Input operation codes.
  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_FEAT   = 2'd1,
    OP_LABEL  = 2'd2,
    OP_FINISH = 2'd3
  } op_t;

  // Configuration register indexes, selected by address bit 2.
  localparam logic REG_PARAM_COUNT = 1'b0;
  localparam logic REG_BATCH_SIZE  = 1'b1;

  // Per-cell control: rotate the chain by one, or load one entry in place.
  typedef struct packed {
    logic shift;
    logic ld_weight;
    logic ld_feat;
  } cell_ctl_t;

  // Signed 64-bit addition that clamps at the signed limits.
  function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sadd64 = s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end else begin
      sadd64 = s[63:0];
    end
  endfunction

  // Clamp a signed 64-bit value into the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v[63] && (v[62:31] != {32{1'b1}})) begin
      sat32 = {1'b1, 31'b0};
    end else if (!v[63] && (v[62:31] != 32'b0)) begin
      sat32 = {1'b0, {31{1'b1}}};
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

@@ rtl/core/lrbg_cell.sv @@
module lrbg_cell import lrbg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cell_ctl_t          ctl,
  input  logic signed [31:0] ld_value,
  input  logic signed [31:0] nb_weight,
  input  logic signed [31:0] nb_feat,
  input  logic signed [63:0] nb_grad,
  output logic signed [31:0] weight,
  output logic signed [31:0] feat,
  output logic signed [63:0] grad
);

  logic signed [31:0] weight_r;
  logic signed [31:0] feat_r;
  logic signed [63:0] grad_r;

  // Weight and feature either take the neighbor's entry or a direct load.
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      weight_r <= nb_weight;
      feat_r   <= nb_feat;
    end else begin
      if (ctl.ld_weight) begin
        weight_r <= ld_value;
      end
      if (ctl.ld_feat) begin
        feat_r <= ld_value;
      end
    end
  end

  // The gradient sum starts at zero and only moves along the chain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grad_r <= '0;
    end else if (ctl.shift) begin
      grad_r <= nb_grad;
    end
  end

  assign weight = weight_r;
  assign feat   = feat_r;
  assign grad   = grad_r;

endmodule

@@ rtl/core/lrbg_div.sv @@
module lrbg_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] dividend,
  input  logic        [15:0] divisor,
  output logic               done,
  output logic signed [31:0] result
);

  logic        busy_r;
  logic        fin_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [63:0] quo_r;
  logic [15:0] rem_r;
  logic [15:0] dvs_r;
  logic        neg_r;
  logic signed [31:0] result_r;

  logic [16:0] rem_sh;
  logic [16:0] rem_sub;
  logic        ge;

  // One quotient bit per cycle on the dividend magnitude.
  assign rem_sh  = {rem_r, quo_r[63]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};
  assign ge      = (rem_sh >= {1'b0, dvs_r});

  // Control: a start launches 64 steps followed by one saturation step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_r <= 1'b0;
        fin_r  <= 1'b1;
      end
    end else if (fin_r) begin
      fin_r  <= 1'b0;
      done_r <= 1'b1;
    end
  end

  // Datapath: magnitude, shift-subtract steps, then sign and clamp.
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[63];
      quo_r <= dividend[63] ? (64'd0 - dividend) : dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[62:0], ge};
      rem_r <= ge ? rem_sub[15:0] : rem_sh[15:0];
    end else if (fin_r) begin
      if (neg_r) begin
        if (quo_r > 64'h0000_0000_8000_0000) begin
          result_r <= {1'b1, 31'b0};
        end else begin
          result_r <= 32'd0 - quo_r[31:0];
        end
      end else begin
        if (quo_r > 64'h0000_0000_7FFF_FFFF) begin
          result_r <= {1'b0, {31{1'b1}}};
        end else begin
          result_r <= quo_r[31:0];
        end
      end
    end
  end

  assign done   = done_r;
  assign result = result_r;

endmodule

@@ rtl/core/linear_regression_batch_gradient_core.sv @@
// Least-squares minibatch gradient engine in signed Q16.16. Weights, sample
// features and gradient sums live in a chain of cells. A weight load writes
// its cell directly and a feature item is multiplied, then accumulated. A
// label forms the error and then rotates the whole chain once past a single
// multiplier, adding feature*error into each active gradient sum. A finish
// item divides each active gradient and the cost by batch_size in a
// bit-serial divider, emits the gradients in index order and then the cost
// flagged last, and leaves all accumulators at zero.
// Registers: param_count at address 0, batch_size at address 4.
module linear_regression_batch_gradient_core import lrbg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic [5:0]         in_index,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_is_cost,
  output logic [5:0]         out_index,
  output logic signed [31:0] out_value,
  output logic               out_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FADD  = 7'b0000010,
    S_LROT  = 7'b0000100,
    S_FDIV  = 7'b0001000,
    S_FWAIT = 7'b0010000,
    S_FCOST = 7'b0100000,
    S_CWAIT = 7'b1000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [5:0]         param_count_r;
  logic [15:0]        batch_r;
  logic signed [63:0] predict_r, predict_nxt;
  logic signed [63:0] cost_r, cost_nxt;
  logic signed [31:0] diff_r, diff_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic signed [47:0] term_r, term_nxt;
  logic signed [63:0] sq_r, sq_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_is_cost_r, out_is_cost_nxt;
  logic [5:0]         out_index_r, out_index_nxt;
  logic signed [31:0] out_value_r, out_value_nxt;
  logic               out_last_r, out_last_nxt;

  cell_ctl_t          ctl [MAX_PARAMS];
  logic signed [31:0] w_q [MAX_PARAMS];
  logic signed [31:0] f_q [MAX_PARAMS];
  logic signed [63:0] g_q [MAX_PARAMS];
  logic signed [31:0] nb_w [MAX_PARAMS];
  logic signed [31:0] nb_f [MAX_PARAMS];
  logic signed [63:0] nb_g [MAX_PARAMS];
  logic signed [63:0] head_grad;

  logic [CNT_W-1:0]   n_act;
  logic               accept;
  logic               slot_free;
  logic               div_start;
  logic signed [63:0] div_dividend;
  logic [15:0]        div_divisor;
  logic               div_done;
  logic signed [31:0] div_result;
  logic signed [31:0] mul_a;
  logic signed [63:0] mul_p;
  logic signed [31:0] pred32;
  logic               cfg_wr;

  // Chain of cells: each takes its right neighbor, the last takes the head.
  for (genvar i = 0; i < MAX_PARAMS; i++) begin : g_cell
    if (i == MAX_PARAMS - 1) begin : g_tail
      assign nb_w[i] = w_q[0];
      assign nb_f[i] = f_q[0];
      assign nb_g[i] = head_grad;
    end else begin : g_mid
      assign nb_w[i] = w_q[i+1];
      assign nb_f[i] = f_q[i+1];
      assign nb_g[i] = g_q[i+1];
    end
    lrbg_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl[i]),
      .ld_value  (in_value),
      .nb_weight (nb_w[i]),
      .nb_feat   (nb_f[i]),
      .nb_grad   (nb_g[i]),
      .weight    (w_q[i]),
      .feat      (f_q[i]),
      .grad      (g_q[i])
    );
  end

  // Serial divider shared by all averages.
  assign div_divisor = (batch_r == 16'd0) ? 16'd1 : batch_r;

  lrbg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .result   (div_result)
  );

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_BATCH_SIZE) ? {16'b0, batch_r} : {26'b0, param_count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      param_count_r <= 6'd16;
      batch_r       <= 16'd1;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_PARAM_COUNT: param_count_r <= pwdata[5:0];
        REG_BATCH_SIZE:  batch_r       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Active entry count and shared operands.
  assign n_act = (param_count_r > 6'(MAX_PARAMS)) ? CNT_W'(MAX_PARAMS)
                                                  : CNT_W'(param_count_r);
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign mul_a     = (cnt_r == '0) ? f_q[0] : f_q[1];
  assign mul_p     = mul_a * diff_r;
  assign pred32    = sat32(predict_r >>> 16);

  // Sequencer and accumulator next values.
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    predict_nxt     = predict_r;
    cost_nxt        = cost_r;
    diff_nxt        = diff_r;
    prod_nxt        = prod_r;
    term_nxt        = term_r;
    sq_nxt          = sq_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_is_cost_nxt = out_is_cost_r;
    out_index_nxt   = out_index_r;
    out_value_nxt   = out_value_r;
    out_last_nxt    = out_last_r;
    head_grad       = g_q[0];
    div_start       = 1'b0;
    div_dividend    = g_q[0];
    for (int k = 0; k < MAX_PARAMS; k++) begin
      ctl[k] = '0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (op_t'(in_op))
            OP_LOAD: begin
              if (in_index < 6'(MAX_PARAMS)) begin
                ctl[in_index[IDX_W-1:0]].ld_weight = 1'b1;
              end
            end
            OP_FEAT: begin
              if ({1'b0, in_index} < 7'(n_act)) begin
                ctl[in_index[IDX_W-1:0]].ld_feat = 1'b1;
                prod_nxt  = w_q[in_index[IDX_W-1:0]] * in_value;
                state_nxt = S_FADD;
              end
            end
            OP_LABEL: begin
              diff_nxt  = sat32({{32{pred32[31]}}, pred32} - {{32{in_value[31]}}, in_value});
              cnt_nxt   = '0;
              state_nxt = S_LROT;
            end
            OP_FINISH: begin
              cnt_nxt   = '0;
              state_nxt = S_FDIV;
            end
            default: ;
          endcase
        end
      end

      S_FADD: begin
        predict_nxt = sadd64(predict_r, prod_r);
        state_nxt   = S_IDLE;
      end

      // Rotate once; the term for the next entry is formed while the head updates.
      S_LROT: begin
        term_nxt = mul_p[63:16];
        if (cnt_r == '0) begin
          sq_nxt  = diff_r * diff_r;
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          for (int k = 0; k < MAX_PARAMS; k++) begin
            ctl[k].shift = 1'b1;
          end
          if (CNT_W'(cnt_r - 1'b1) < n_act) begin
            head_grad = sadd64(g_q[0], {{16{term_r[47]}}, term_r});
          end
          if (cnt_r == CNT_W'(1)) begin
            cost_nxt = sadd64(cost_r, {17'b0, sq_r[63:17]});
          end
          if (cnt_r == CNT_W'(MAX_PARAMS)) begin
            predict_nxt = '0;
            state_nxt   = S_IDLE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end

      // Hand the head sum to the divider while clearing it along the chain.
      S_FDIV: begin
        for (int k = 0; k < MAX_PARAMS; k++) begin
          ctl[k].shift = 1'b1;
        end
        head_grad = '0;
        if (cnt_r < n_act) begin
          div_start = 1'b1;
          state_nxt = S_FWAIT;
        end else if (cnt_r == CNT_W'(MAX_PARAMS - 1)) begin
          state_nxt = S_FCOST;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_FWAIT: begin
        if (div_done && slot_free) begin
          out_valid_nxt   = 1'b1;
          out_is_cost_nxt = 1'b0;
          out_index_nxt   = 6'(cnt_r);
          out_value_nxt   = div_result;
          out_last_nxt    = 1'b0;
          if (cnt_r == CNT_W'(MAX_PARAMS - 1)) begin
            state_nxt = S_FCOST;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_FDIV;
          end
        end
      end

      S_FCOST: begin
        div_start    = 1'b1;
        div_dividend = cost_r;
        cost_nxt     = '0;
        predict_nxt  = '0;
        state_nxt    = S_CWAIT;
      end

      S_CWAIT: begin
        if (div_done && slot_free) begin
          out_valid_nxt   = 1'b1;
          out_is_cost_nxt = 1'b1;
          out_index_nxt   = '0;
          out_value_nxt   = div_result;
          out_last_nxt    = 1'b1;
          state_nxt       = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and accumulator registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      predict_r   <= '0;
      cost_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      predict_r   <= predict_nxt;
      cost_r      <= cost_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    diff_r        <= diff_nxt;
    prod_r        <= prod_nxt;
    term_r        <= term_nxt;
    sq_r          <= sq_nxt;
    out_is_cost_r <= out_is_cost_nxt;
    out_index_r   <= out_index_nxt;
    out_value_r   <= out_value_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_is_cost = out_is_cost_r;
  assign out_index   = out_index_r;
  assign out_value   = out_value_r;
  assign out_last    = out_last_r;

  // Only the cost transaction closes a finish run.
  a_last_is_cost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_is_cost)
    else $error("last flag on a gradient transaction");

  // The cost transaction carries index zero.
  a_cost_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_cost |-> (out_index == 6'd0))
    else $error("cost transaction with nonzero index");

  // A label rotation ends back in idle with the prediction cleared.
  a_label_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LROT) && (cnt_r == CNT_W'(MAX_PARAMS)) |=>
      (state_r == S_IDLE) && (predict_r == '0))
    else $error("label rotation did not close cleanly");

  // The sequencer state stays one-hot.
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

endmodule

@@ test/linear_regression_batch_gradient_core_checker.sv @@
// Watches both channels and the register port, predicts the gradient and cost
// results of every finish transaction and compares them with what comes out.
module linear_regression_batch_gradient_core_checker import lrbg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic [5:0]         in_index,
  input  logic signed [31:0] in_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_is_cost,
  input  logic [5:0]         out_index,
  input  logic signed [31:0] out_value,
  input  logic               out_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 fails,
  output int                 pending
);

  typedef struct {
    logic               is_cost;
    logic [5:0]         index;
    logic signed [31:0] value;
    logic               last;
  } grad_result_t;

  grad_result_t       avg_results_q[$];
  logic [5:0]         param_count;
  logic [15:0]        batch_size;
  logic signed [31:0] weight_mem [MAX_PARAMS];
  logic signed [31:0] feat_mem [MAX_PARAMS];
  longint             grad_acc [MAX_PARAMS];
  longint             dot_acc;
  longint             cost_acc;

  assign pending = avg_results_q.size();

  // Signed 64-bit sum clamped at the limits.
  function automatic longint clamp_add(longint a, longint b);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      return a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
    end
    return s;
  endfunction

  // Clamp into the signed 32-bit range.
  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic int active_width();
    return (param_count < MAX_PARAMS) ? int'(param_count) : MAX_PARAMS;
  endfunction

  // Advance the model by one accepted input transaction.
  task automatic apply_item(op_t op, int idx, logic signed [31:0] val);
    int           n;
    longint       predict;
    longint       diff;
    longint       div;
    longint       dv;
    grad_result_t r;
    n  = active_width();
    dv = val;
    case (op)
      OP_LOAD: begin
        if (idx < MAX_PARAMS) weight_mem[idx] = val;
      end
      OP_FEAT: begin
        if (idx < n) begin
          feat_mem[idx] = val;
          dot_acc = clamp_add(dot_acc, longint'(weight_mem[idx]) * dv);
        end
      end
      OP_LABEL: begin
        predict = clamp32(dot_acc >>> 16);
        diff = clamp32(predict - dv);
        for (int i = 0; i < n; i++) begin
          grad_acc[i] = clamp_add(grad_acc[i], (longint'(feat_mem[i]) * diff) >>> 16);
        end
        cost_acc = clamp_add(cost_acc, (diff * diff) >>> 17);
        dot_acc = 0;
      end
      default: begin
        div = (batch_size == 0) ? 1 : longint'(batch_size);
        for (int i = 0; i < n; i++) begin
          r.is_cost = 1'b0;
          r.index = 6'(i);
          r.value = 32'(clamp32(grad_acc[i] / div));
          r.last = 1'b0;
          avg_results_q.push_back(r);
        end
        // Every gradient sum is cleared, active or not.
        for (int i = 0; i < MAX_PARAMS; i++) begin
          grad_acc[i] = 0;
        end
        r.is_cost = 1'b1;
        r.index = 6'd0;
        r.value = 32'(clamp32(cost_acc / div));
        r.last = 1'b1;
        avg_results_q.push_back(r);
        cost_acc = 0;
        dot_acc = 0;
      end
    endcase
  endtask

  // Track register writes, inputs and results at every rising edge.
  always @(posedge clk) begin
    grad_result_t exp_r;
    if (!rst_n) begin
      param_count = 6'd16;
      batch_size = 16'd1;
      dot_acc = 0;
      cost_acc = 0;
      for (int i = 0; i < MAX_PARAMS; i++) begin
        grad_acc[i] = 0;
        weight_mem[i] = 0;
        feat_mem[i] = 0;
      end
      avg_results_q.delete();
      fails = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_BATCH_SIZE) batch_size = pwdata[15:0];
        else param_count = pwdata[5:0];
      end
      if (in_valid && !in_stall) apply_item(op_t'(in_op), int'(in_index), in_value);
      if (out_valid && !out_stall) begin
        if (avg_results_q.size() == 0) begin
          $error("result transaction with nothing expected: index %0d value %0d",
                 out_index, out_value);
          fails++;
        end else begin
          exp_r = avg_results_q.pop_front();
          if (out_is_cost !== exp_r.is_cost) begin
            $error("is_cost: expected %0d, got %0d", exp_r.is_cost, out_is_cost);
            fails++;
          end
          if (out_index !== exp_r.index) begin
            $error("out_index: expected %0d, got %0d", exp_r.index, out_index);
            fails++;
          end
          if (out_value !== exp_r.value) begin
            $error("out_value: expected %0d, got %0d", exp_r.value, out_value);
            fails++;
          end
          if (out_last !== exp_r.last) begin
            $error("last: expected %0d, got %0d", exp_r.last, out_last);
            fails++;
          end
        end
      end
    end
  end

endmodule

@@ test/linear_regression_batch_gradient_core_tb.sv @@
module linear_regression_batch_gradient_core_tb;
  import lrbg_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_op;
  logic [5:0]         in_index;
  logic signed [31:0] in_value;
  logic               out_valid;
  logic               out_stall;
  logic               out_is_cost;
  logic [5:0]         out_index;
  logic signed [31:0] out_value;
  logic               out_last;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  int                 fails;
  int                 pending;
  int                 tx_gap_max;
  int                 rx_gap_max;
  int                 rx_hold;
  int                 idle_cycles;
  int                 cur_width;

  linear_regression_batch_gradient_core u_top (.*);

  linear_regression_batch_gradient_core_checker u_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_op, .in_index, .in_value,
    .out_valid, .out_stall, .out_is_cost, .out_index, .out_value, .out_last,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .fails, .pending
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: random stall per result, plus one long hold-off on request.
  initial begin
    logic took;
    int   gap;
    out_stall = 1'b0;
    rx_hold = 0;
    gap = 0;
    forever begin
      @(posedge clk);
      took = out_valid && !out_stall;
      @(negedge clk);
      if (took) gap = $urandom_range(0, rx_gap_max);
      if (rx_hold > 0) begin
        out_stall <= 1'b1;
        rx_hold--;
      end else if (gap > 0) begin
        out_stall <= 1'b1;
        gap--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("linear_regression_batch_gradient_core regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one input transaction after a random gap and wait until it is taken.
  task automatic send(op_t op, int idx, logic [31:0] val);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_op <= op;
    in_index <= 6'(idx);
    in_value <= val;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
  endtask

  // Two-phase register write; only issued while the block is idle.
  task automatic write_reg(logic sel, logic [31:0] data);
    @(negedge clk);
    in_valid <= 1'b0;
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Stop offering inputs and wait until every expected result has been taken.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3, 4: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  // One sample: the features of the active width, some noise, then its label.
  task automatic send_sample();
    if ($urandom_range(0, 3) == 0) send(OP_LOAD, $urandom_range(0, 63), pick_value());
    for (int i = 0; i < cur_width; i++) begin
      send(OP_FEAT, i, pick_value());
    end
    if (cur_width > 0 && $urandom_range(0, 4) == 0) begin
      send(OP_FEAT, $urandom_range(0, cur_width - 1), pick_value());
    end
    if ($urandom_range(0, 4) == 0) send(OP_FEAT, $urandom_range(cur_width, 63), pick_value());
    send(OP_LABEL, $urandom_range(0, 63), pick_value());
  endtask

  initial begin
    logic [5:0]  pc_list [7] = '{6'd1, 6'd63, 6'd0, 6'd5, 6'd16, 6'd9, 6'd3};
    logic [15:0] bs_list [7] = '{16'd0, 16'd65535, 16'd3, 16'd2, 16'd1, 16'd7, 16'd1};
    int          sent;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_LOAD;
    in_index = '0;
    in_value = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_cycles = 0;
    tx_gap_max = 0;
    rx_gap_max = 0;
    cur_width = MAX_PARAMS;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Fill every weight and feature so no unwritten entry is ever read.
    for (int i = 0; i < MAX_PARAMS; i++) send(OP_LOAD, i, pick_value());
    for (int i = 0; i < MAX_PARAMS; i++) send(OP_FEAT, i, pick_value());
    send(OP_LABEL, 0, 32'h0);

    // Directed: extreme weights, features and labels, an empty finish.
    send(OP_FINISH, 0, 32'h0);
    send(OP_LOAD, 0, 32'h7fff_ffff);
    send(OP_LOAD, 1, 32'h8000_0000);
    send(OP_LOAD, 63, 32'hffff_ffff);
    send(OP_FEAT, 0, 32'h7fff_ffff);
    send(OP_FEAT, 1, 32'h8000_0000);
    send(OP_FEAT, 1, 32'h8000_0000);
    send(OP_LABEL, 63, 32'h8000_0000);
    send(OP_FEAT, 0, 32'h8000_0000);
    send(OP_FEAT, 1, 32'h8000_0000);
    send(OP_LABEL, 0, 32'h7fff_ffff);
    send(OP_LABEL, 42, 32'h0001_0000);
    send(OP_FINISH, 21, 32'h5555_aaaa);
    send(OP_FINISH, 63, 32'hffff_ffff);
    drain();

    // Random phases across several register settings.
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(REG_PARAM_COUNT, {$urandom & 32'hffff_ffc0} | pc_list[ph]);
      write_reg(REG_BATCH_SIZE, {$urandom & 32'hffff_0000} | bs_list[ph]);
      cur_width = (pc_list[ph] < MAX_PARAMS) ? pc_list[ph] : MAX_PARAMS;
      tx_gap_max = (ph % 3 == 1) ? 0 : 18;
      rx_gap_max = (ph % 3 == 2) ? 0 : 18;
      if (ph == 4) begin
        // Hold the receiver off while inputs keep arriving behind a finish.
        tx_gap_max = 0;
        send_sample();
        send(OP_FINISH, 0, pick_value());
        rx_hold = 600;
      end
      sent = 0;
      while (sent < 18) begin
        for (int s = $urandom_range(1, 3); s > 0; s--) begin
          send_sample();
          sent += cur_width + 2;
        end
        send(OP_FINISH, $urandom_range(0, 63), pick_value());
        sent++;
      end
      drain();
    end

    if (fails == 0) begin
      $display("linear_regression_batch_gradient_core regression: pass");
    end else begin
      $display("linear_regression_batch_gradient_core regression: fail");
    end
    $finish;
  end

endmodule
